### rtl/core/rtfi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfi_pkg
// Shared constants, calibration tables and stage payload types for the
// range to focus interpolator.
// ----------------------------------------------------------------------------
package rtfi_pkg;

  // Calibration table size. Rows past the calibrated ones repeat the last row.
  localparam int TABLE_ROWS   = 11;
  localparam int LUT_SLOTS    = 16;
  localparam int POS_W        = 4;
  localparam int SEG_LAST_RAW = (TABLE_ROWS - 1) % LUT_SLOTS;
  localparam int SEG_LAST     = (SEG_LAST_RAW < 1) ? 1 : SEG_LAST_RAW;

  // Field and datapath widths.
  localparam int DIST_W      = 16;
  localparam int OFFSET_W    = 10;
  localparam int CODE_W      = 12;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 16;
  localparam int V_W         = 21;   // signed millimetres, -1023 .. 655350
  localparam int MM_W        = 20;   // breakpoints up to 1000001 mm
  localparam int FRAC_W      = 15;   // fractions in units of 1/20480
  localparam int DIFF_W      = 12;   // fraction step of one segment
  localparam int W_W         = 21;   // signed distance into the segment
  localparam int BD_W        = 24;
  localparam int DEN_W       = 24;   // ten times the segment width
  localparam int N_W         = 33;   // signed numerator
  localparam int MAG_W       = 32;   // numerator magnitude
  localparam int HALF_W      = 16;
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 29;
  localparam int PP_W        = HALF_W + RECIP_W;
  localparam int SUM_W       = PP_W + HALF_W;
  localparam int QUO_W       = SUM_W - RECIP_SHIFT;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_LENS_OFFSET = 1'b0;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 10'd145;

  // Output queue.
  localparam int QUEUE_DEPTH = 16;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MM_W-1:0] LUT_MM [LUT_SLOTS] = '{
    20'd0, 20'd250, 20'd265, 20'd325, 20'd425, 20'd645, 20'd1560, 20'd2975,
    20'd6790, 20'd1000000, 20'd1000001, 20'd1000001, 20'd1000001,
    20'd1000001, 20'd1000001, 20'd1000001
  };

  localparam logic [FRAC_W-1:0] LUT_FRAC [LUT_SLOTS] = '{
    15'd0, 15'd2560, 15'd5120, 15'd7680, 15'd10240, 15'd12800, 15'd15360,
    15'd16384, 15'd16896, 15'd17920, 15'd20480, 15'd20480, 15'd20480,
    15'd20480, 15'd20480, 15'd20480
  };

  // Lower breakpoint of the segment that ends at row p.
  function automatic logic [MM_W-1:0] seg_lo_mm(input logic [POS_W-1:0] p);
    return LUT_MM[p - POS_W'(1)];
  endfunction

  function automatic logic [MM_W-1:0] seg_width(input logic [POS_W-1:0] p);
    return LUT_MM[p] - LUT_MM[p - POS_W'(1)];
  endfunction

  function automatic logic [DEN_W-1:0] seg_den(input logic [POS_W-1:0] p);
    return DEN_W'(seg_width(p)) * DEN_W'(10);
  endfunction

  function automatic logic [DIFF_W-1:0] seg_slope(input logic [POS_W-1:0] p);
    return DIFF_W'(LUT_FRAC[p] - LUT_FRAC[p - POS_W'(1)]);
  endfunction

  // Whole part of the lower fraction scaled to the output code.
  function automatic logic [CODE_W-1:0] seg_base(input logic [POS_W-1:0] p);
    return CODE_W'(LUT_FRAC[p - POS_W'(1)] / 10);
  endfunction

  // Leftover tenths of the lower fraction, times the segment width.
  function automatic logic [BD_W-1:0] seg_bias(input logic [POS_W-1:0] p);
    logic [BD_W-1:0] tenths;
    tenths = BD_W'(LUT_FRAC[p - POS_W'(1)] % 10);
    return tenths * BD_W'(seg_width(p));
  endfunction

  localparam logic [RECIP_SHIFT:0] RECIP_ONE = {1'b1, {RECIP_SHIFT{1'b0}}};

  // floor(2^32 / (10 * width)) per segment; zero-width rows carry no slope.
  localparam logic [RECIP_W-1:0] SEG_RECIP [LUT_SLOTS] = '{
    '0,
    RECIP_W'(RECIP_ONE / seg_den(4'd1)),
    RECIP_W'(RECIP_ONE / seg_den(4'd2)),
    RECIP_W'(RECIP_ONE / seg_den(4'd3)),
    RECIP_W'(RECIP_ONE / seg_den(4'd4)),
    RECIP_W'(RECIP_ONE / seg_den(4'd5)),
    RECIP_W'(RECIP_ONE / seg_den(4'd6)),
    RECIP_W'(RECIP_ONE / seg_den(4'd7)),
    RECIP_W'(RECIP_ONE / seg_den(4'd8)),
    RECIP_W'(RECIP_ONE / seg_den(4'd9)),
    RECIP_W'(RECIP_ONE / seg_den(4'd10)),
    '0, '0, '0, '0, '0
  };

  typedef struct packed {
    logic                  vld;
    logic [POS_W-1:0]      pos;
    logic signed [W_W-1:0] ofs;
  } seg_item_t;

  typedef struct packed {
    logic             vld;
    logic [POS_W-1:0] pos;
    logic             neg;
    logic [MAG_W-1:0] mag;
  } num_item_t;

endpackage

### rtl/core/range_to_focus_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_to_focus_interpolator
// Converts a rangefinder distance into a lens focus code by piecewise linear
// interpolation over a fixed calibration table.
// ----------------------------------------------------------------------------
// Usage:
// Each item on the in_ channel carries one distance in centimetres. The block
// scales it to millimetres, subtracts the lens offset register, picks the
// calibration segment and returns one focus code item on the out_ channel,
// in the same order as the distances arrived.
// Throughput is one item per clock cycle while in_tready is high. Between input
// acceptance and out_tvalid lie ten pipeline stages (scale, compare, select,
// segment offset, numerator, magnitude, two reciprocal stages, back product,
// correction) and the output queue write.
// The pipeline itself never stalls. Results land in a 16-entry output queue,
// and in_tready stays high while fewer than 16 items are accepted but not yet
// delivered, so a stalled receiver stops intake only after that many items.
// Reset (synchronous, active low) empties the pipeline and the queue and
// sets the lens offset to 145 mm. The offset register is written over the
// APB port at byte address 0 and should only change while the block is idle.
// ----------------------------------------------------------------------------
module range_to_focus_interpolator (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input items.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rtfi_pkg::IN_DATA_W-1:0]     in_tdata,    // [15:0] distance_cm
  // Result items.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rtfi_pkg::OUT_DATA_W-1:0]    out_tdata,   // [11:0] focus_code, [15:12] zero
  // Configuration port.
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [rtfi_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [rtfi_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [rtfi_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  localparam int OFFSET_W = rtfi_pkg::OFFSET_W;
  localparam int CODE_W   = rtfi_pkg::CODE_W;

  logic [OFFSET_W-1:0]     offset_r;
  logic                    cfg_wr;
  logic                    cfg_hit;
  logic                    in_take;
  rtfi_pkg::seg_item_t     seg;
  rtfi_pkg::num_item_t     num;
  logic                    code_vld;
  logic [CODE_W-1:0]       code;
  logic [CODE_W-1:0]       out_code;

  // The register index is the word address; byte lanes are ignored.
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == rtfi_pkg::REG_LENS_OFFSET);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_hit ? rtfi_pkg::CFG_DATA_W'(offset_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= rtfi_pkg::OFFSET_RESET;
    end else if (cfg_wr && cfg_hit) begin
      offset_r <= cfg_pwdata[OFFSET_W-1:0];
    end
  end

  assign in_take = in_tvalid && in_tready;

  rtfi_locate u_locate (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_take),
    .in_dist (in_tdata[rtfi_pkg::DIST_W-1:0]),
    .offset  (offset_r),
    .seg_o   (seg)
  );

  rtfi_numer u_numer (
    .clk   (clk),
    .rst_n (rst_n),
    .seg_i (seg),
    .num_o (num)
  );

  rtfi_divide u_divide (
    .clk      (clk),
    .rst_n    (rst_n),
    .num_i    (num),
    .code_vld (code_vld),
    .code     (code)
  );

  // The in-flight count in the queue holds intake back before it can overflow.
  rtfi_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (in_take),
    .wr_vld   (code_vld),
    .wr_code  (code),
    .rd_ready (out_tready),
    .rd_vld   (out_tvalid),
    .rd_code  (out_code),
    .space    (in_tready)
  );

  assign out_tdata = {{(rtfi_pkg::OUT_DATA_W - CODE_W){1'b0}}, out_code};

endmodule

### rtl/core/rtfi_locate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfi_locate
// Scales the distance to millimetres, finds the table segment and the
// distance into that segment. Four register stages.
// ----------------------------------------------------------------------------
module rtfi_locate (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  logic [rtfi_pkg::DIST_W-1:0]      in_dist,
  input  logic [rtfi_pkg::OFFSET_W-1:0]    offset,
  output rtfi_pkg::seg_item_t              seg_o
);

  localparam int V_W   = rtfi_pkg::V_W;
  localparam int POS_W = rtfi_pkg::POS_W;
  localparam int SLOTS = rtfi_pkg::LUT_SLOTS;

  logic                    vld1_r, vld2_r, vld3_r, vld4_r;
  logic signed [V_W-1:0]   v1_r, v2_r, v3_r;
  logic signed [V_W-1:0]   v1_nxt;
  logic [SLOTS-1:1]        le2_r, le2_nxt;
  logic [POS_W-1:0]        pos3_r, pos3_nxt, pos4_r;
  logic signed [rtfi_pkg::W_W-1:0] ofs4_r, ofs4_nxt;
  logic [V_W-1:0]          scaled;

  always_comb begin
    // Times ten as two shifted copies.
    scaled = (V_W'(in_dist) << 3) + (V_W'(in_dist) << 1);
    v1_nxt = signed'(scaled - V_W'(offset));
  end

  always_comb begin
    for (int k = 1; k < SLOTS; k++) begin
      le2_nxt[k] = (v1_r <= signed'({1'b0, rtfi_pkg::LUT_MM[k]}));
    end
  end

  // First row whose breakpoint is not below v; the last row catches the rest.
  always_comb begin
    pos3_nxt = POS_W'(rtfi_pkg::SEG_LAST);
    for (int k = SLOTS - 1; k >= 1; k--) begin
      if (k < rtfi_pkg::SEG_LAST && le2_r[k]) begin
        pos3_nxt = POS_W'(k);
      end
    end
  end

  always_comb begin
    ofs4_nxt = v3_r - signed'({1'b0, rtfi_pkg::seg_lo_mm(pos3_r)});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    v1_r   <= v1_nxt;
    v2_r   <= v1_r;
    le2_r  <= le2_nxt;
    v3_r   <= v2_r;
    pos3_r <= pos3_nxt;
    pos4_r <= pos3_r;
    ofs4_r <= ofs4_nxt;
  end

  assign seg_o.vld = vld4_r;
  assign seg_o.pos = pos4_r;
  assign seg_o.ofs = ofs4_r;

endmodule

### rtl/core/rtfi_numer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfi_numer
// Forms the interpolation numerator and splits it into sign and magnitude.
// Two register stages.
// ----------------------------------------------------------------------------
module rtfi_numer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rtfi_pkg::seg_item_t    seg_i,
  output rtfi_pkg::num_item_t    num_o
);

  localparam int N_W    = rtfi_pkg::N_W;
  localparam int PROD_W = rtfi_pkg::W_W + rtfi_pkg::DIFF_W + 1;

  logic                           vld5_r, vld6_r;
  logic [rtfi_pkg::POS_W-1:0]     pos5_r, pos6_r;
  logic signed [PROD_W-1:0]       prod, total;
  logic signed [N_W-1:0]          n5_r, n5_nxt;
  logic                           neg6_r, neg6_nxt;
  logic [rtfi_pkg::MAG_W-1:0]     mag6_r, mag6_nxt;

  // The table keeps the magnitude below 2^32 for every reachable distance.
  always_comb begin
    prod   = seg_i.ofs * signed'({1'b0, rtfi_pkg::seg_slope(seg_i.pos)});
    total  = prod + signed'(PROD_W'(rtfi_pkg::seg_bias(seg_i.pos)));
    n5_nxt = signed'(N_W'(total));
  end

  always_comb begin
    neg6_nxt = n5_r[N_W-1];
    mag6_nxt = neg6_nxt ? rtfi_pkg::MAG_W'(-n5_r) : rtfi_pkg::MAG_W'(n5_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else begin
      vld5_r <= seg_i.vld;
      vld6_r <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    n5_r   <= n5_nxt;
    pos5_r <= seg_i.pos;
    pos6_r <= pos5_r;
    neg6_r <= neg6_nxt;
    mag6_r <= mag6_nxt;
  end

  assign num_o.vld = vld6_r;
  assign num_o.pos = pos6_r;
  assign num_o.neg = neg6_r;
  assign num_o.mag = mag6_r;

endmodule

### rtl/core/rtfi_divide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfi_divide
// Divides the numerator by ten times the segment width through a per-segment
// reciprocal, corrects the quotient by one step and adds the whole part.
// Four register stages.
// ----------------------------------------------------------------------------
module rtfi_divide (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rtfi_pkg::num_item_t          num_i,
  output logic                         code_vld,
  output logic [rtfi_pkg::CODE_W-1:0]  code
);

  localparam int POS_W  = rtfi_pkg::POS_W;
  localparam int MAG_W  = rtfi_pkg::MAG_W;
  localparam int HALF_W = rtfi_pkg::HALF_W;
  localparam int PP_W   = rtfi_pkg::PP_W;
  localparam int SUM_W  = rtfi_pkg::SUM_W;
  localparam int QUO_W  = rtfi_pkg::QUO_W;
  localparam int CODE_W = rtfi_pkg::CODE_W;
  localparam int BACK_W = QUO_W + rtfi_pkg::DEN_W;

  logic                    vld7_r, vld8_r, vld9_r, vld10_r;
  logic [POS_W-1:0]        pos7_r, pos8_r, pos9_r;
  logic                    neg7_r, neg8_r, neg9_r;
  logic [MAG_W-1:0]        mag7_r, mag8_r, mag9_r;
  logic [PP_W-1:0]         pp_hi7_r, pp_lo7_r, pp_hi7_nxt, pp_lo7_nxt;
  logic [rtfi_pkg::RECIP_W-1:0] recip;
  logic [SUM_W-1:0]        sum;
  logic [QUO_W-1:0]        q8_r, q8_nxt, q9_r, qc;
  logic [BACK_W-1:0]       back_full;
  logic [MAG_W-1:0]        back9_r, back9_nxt, rem;
  logic [rtfi_pkg::DEN_W-1:0] den;
  logic                    fix;
  logic [CODE_W-1:0]       code10_r, code10_nxt, q_code;

  always_comb begin
    recip      = rtfi_pkg::SEG_RECIP[num_i.pos];
    pp_hi7_nxt = num_i.mag[MAG_W-1:HALF_W] * recip;
    pp_lo7_nxt = num_i.mag[HALF_W-1:0] * recip;
  end

  always_comb begin
    sum    = {pp_hi7_r, {HALF_W{1'b0}}} + SUM_W'(pp_lo7_r);
    q8_nxt = sum[SUM_W-1:rtfi_pkg::RECIP_SHIFT];
  end

  // The estimate never exceeds the true quotient, so the product fits.
  always_comb begin
    back_full = q8_r * rtfi_pkg::seg_den(pos8_r);
    back9_nxt = back_full[MAG_W-1:0];
  end

  // The estimate is the true quotient or one below it.
  always_comb begin
    den        = rtfi_pkg::seg_den(pos9_r);
    rem        = mag9_r - back9_r;
    fix        = (den != '0) && (MAG_W'(den) <= rem);
    qc         = q9_r + QUO_W'(fix);
    q_code     = CODE_W'(qc);
    code10_nxt = rtfi_pkg::seg_base(pos9_r) + (neg9_r ? (CODE_W'(0) - q_code) : q_code);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld7_r  <= 1'b0;
      vld8_r  <= 1'b0;
      vld9_r  <= 1'b0;
      vld10_r <= 1'b0;
    end else begin
      vld7_r  <= num_i.vld;
      vld8_r  <= vld7_r;
      vld9_r  <= vld8_r;
      vld10_r <= vld9_r;
    end
  end

  always_ff @(posedge clk) begin
    pos7_r   <= num_i.pos;
    neg7_r   <= num_i.neg;
    mag7_r   <= num_i.mag;
    pp_hi7_r <= pp_hi7_nxt;
    pp_lo7_r <= pp_lo7_nxt;
    pos8_r   <= pos7_r;
    neg8_r   <= neg7_r;
    mag8_r   <= mag7_r;
    q8_r     <= q8_nxt;
    pos9_r   <= pos8_r;
    neg9_r   <= neg8_r;
    mag9_r   <= mag8_r;
    q9_r     <= q8_r;
    back9_r  <= back9_nxt;
    code10_r <= code10_nxt;
  end

  assign code_vld = vld10_r;
  assign code     = code10_r;

endmodule

### rtl/core/rtfi_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfi_fifo
// Output queue with an in-flight count, so the pipeline never has to stall.
// ----------------------------------------------------------------------------
module rtfi_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic                         wr_vld,
  input  logic [rtfi_pkg::CODE_W-1:0]  wr_code,
  input  logic                         rd_ready,
  output logic                         rd_vld,
  output logic [rtfi_pkg::CODE_W-1:0]  rd_code,
  output logic                         space
);

  localparam int AW = rtfi_pkg::QUEUE_AW;
  localparam int CW = rtfi_pkg::QUEUE_CW;

  logic [rtfi_pkg::CODE_W-1:0] mem [rtfi_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] fill_r, fill_nxt, occ_r, occ_nxt;
  logic          pop;

  assign rd_vld  = (fill_r != '0);
  assign rd_code = mem[rd_ptr_r];
  assign pop     = rd_vld && rd_ready;
  // Items accepted but not yet delivered, wherever they are.
  assign space   = (occ_r < CW'(rtfi_pkg::QUEUE_DEPTH));

  always_comb begin
    fill_nxt = fill_r + CW'(wr_vld) - CW'(pop);
    occ_nxt  = occ_r + CW'(take) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      occ_r    <= '0;
    end else begin
      fill_r <= fill_nxt;
      occ_r  <= occ_nxt;
      if (wr_vld) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_vld) begin
      mem[wr_ptr_r] <= wr_code;
    end
  end

endmodule

### rtl/core/rtfi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtfi_checker
// Port-level checks on the interpolator's channels, bound to the top level.
// ----------------------------------------------------------------------------
module rtfi_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [rtfi_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [rtfi_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int LATENCY = 11;

  // A waiting result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // An accepted item must find out_tvalid high once the pipeline latency has passed.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##LATENCY out_tvalid)
    else $error("no result after pipeline latency");

  // Intake only stops when results are piled up waiting.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("intake stopped with no result waiting");

  // Right after reset nothing comes out and intake is open.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("block not empty after reset");

  // Padding bits above the code stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[rtfi_pkg::OUT_DATA_W-1:rtfi_pkg::CODE_W] == '0)
    else $error("nonzero padding in result");

endmodule

bind range_to_focus_interpolator rtfi_checker u_rtfi_checker (.*);
